// ----- src/dmrg_pkg.sv -----
`default_nettype none

package dmrg_pkg;

  localparam int WordW  = 32;
  localparam int StateW = 64;

  localparam logic [WordW-1:0] MulOne = 32'd4294095429;
  localparam logic [WordW-1:0] MulTwo = 32'd4293977883;
  localparam logic [WordW-1:0] LcgMul = 32'd3571494541;
  localparam logic [WordW-1:0] LcgAdd = 32'd3753453877;

  localparam int SeedWords     = 5;
  localparam int SeedStepLimit = 32;
  localparam int PhaseW        = $clog2(SeedWords + 1);
  localparam int StepW         = $clog2(SeedStepLimit + 1);

  typedef enum logic [1:0] {
    OpDraw = 2'd0,
    OpSeed = 2'd1,
    OpLoad = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    MacGenOne = 2'd0,
    MacGenTwo = 2'd1,
    MacLcg    = 2'd2
  } mac_sel_e;

endpackage

`default_nettype wire

// ----- src/dmrg_if.sv -----
`default_nettype none

interface dmrg_in_if import dmrg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [WordW-1:0]  seed_value;
  logic [WordW-1:0]  load_word0;
  logic [WordW-1:0]  load_word1;
  logic [WordW-1:0]  load_word2;
  logic [WordW-1:0]  load_word3;

  modport source (
    output valid, opcode, seed_value, load_word0, load_word1, load_word2, load_word3,
    input  ready
  );
  modport sink (
    input  valid, opcode, seed_value, load_word0, load_word1, load_word2, load_word3,
    output ready
  );
endinterface

interface dmrg_out_if import dmrg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [StateW-1:0] random_value;
  logic [StateW-1:0] first_state;
  logic [StateW-1:0] second_state;

  modport source (
    output valid, random_value, first_state, second_state,
    input  ready
  );
  modport sink (
    input  valid, random_value, first_state, second_state,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/dmrg_mac.sv -----
`default_nettype none

module dmrg_mac import dmrg_pkg::*; (
  input  wire logic [WordW-1:0]  a_i,
  input  wire logic [WordW-1:0]  b_i,
  input  wire logic [WordW-1:0]  c_i,
  output logic      [StateW-1:0] p_o
);

  assign p_o = StateW'(a_i) * StateW'(b_i) + StateW'(c_i);

endmodule

`default_nettype wire

// ----- src/dual_mwc_random_generator_unit.sv -----
// Combined multiply-with-carry random generator with a 64-bit result.
// in_i takes one command beat: draw, reseed from seed_value, or load both
// generator states from the four load words. out_o returns one beat per
// command: the draw (zero for other commands) and both states afterwards,
// which also serves to read the state back.
// One 32x32 multiply-add unit does every multiply step: first generator, second
// generator, or one LCG step of a reseed, one step a cycle.
// A draw steps the first generator, then the second, then sums them; a load or
// unused opcode goes straight to its result beat. A reseed runs 5 to 32 LCG
// steps (usually 5 or 6), then WARMUP_DRAWS warm-up draws. in_i.ready is low from
// accept until the result beat has been written to the output register,
// so no new command is taken while one is still in flight.
// Reset starts a reseed with seed 0 that produces no result beat; in_i.ready
// stays low for its duration.
// A stalled receiver holds the result in the output register; a following
// command is accepted and runs, then waits until the register frees.
`default_nettype none

module dual_mwc_random_generator_unit import dmrg_pkg::*; #(
  parameter int WARMUP_DRAWS = 13
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dmrg_in_if.sink     in_i,
  dmrg_out_if.source  out_o
);

  localparam int WarmW = (WARMUP_DRAWS > 1) ? $clog2(WARMUP_DRAWS) : 1;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StDrawA = 3'd1;
  localparam logic [2:0] StDrawB = 3'd2;
  localparam logic [2:0] StSum   = 3'd3;
  localparam logic [2:0] StLcg   = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [StateW-1:0] g1_q, g1_d, g2_q, g2_d;
  logic [StateW-1:0] value_q, value_d;
  logic [WordW-1:0]  seed_q, seed_d, lcg_q, lcg_d;
  logic [PhaseW-1:0] phase_q, phase_d, phase_nx;
  logic [StepW-1:0]  steps_q, steps_d, steps_nx;
  logic [WarmW-1:0]  warm_q, warm_d;
  logic              seeding_q, seeding_d;
  logic              emit_q, emit_d;
  logic              out_valid_q, out_valid_d;
  logic [StateW-1:0] out_value_q, out_g1_q, out_g2_q;
  logic              out_load;

  mac_sel_e          mac_sel;
  logic [WordW-1:0]  mac_a, mac_b, mac_c, z_word;
  logic [StateW-1:0] mac_p;
  logic              accept, z_keep;

  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == StIdle);

  always_comb begin
    mac_sel = MacGenOne;
    if (state_q == StDrawB) begin
      mac_sel = MacGenTwo;
    end else if (state_q == StLcg) begin
      mac_sel = MacLcg;
    end
  end

  always_comb begin
    case (mac_sel)
      MacGenOne: begin
        mac_a = g1_q[WordW-1:0];
        mac_b = MulOne;
        mac_c = g1_q[StateW-1:WordW];
      end
      MacGenTwo: begin
        mac_a = g2_q[WordW-1:0];
        mac_b = MulTwo;
        mac_c = g2_q[StateW-1:WordW];
      end
      MacLcg: begin
        mac_a = lcg_q + seed_q;
        mac_b = LcgMul;
        mac_c = LcgAdd;
      end
      default: begin
        mac_a = '0;
        mac_b = '0;
        mac_c = '0;
      end
    endcase
  end

  dmrg_mac u_mac (
    .a_i (mac_a),
    .b_i (mac_b),
    .c_i (mac_c),
    .p_o (mac_p)
  );

  assign z_word   = {1'b0, mac_p[WordW-2:0]};
  assign z_keep   = (mac_p[WordW-2:0] != '0);
  assign phase_nx = z_keep ? phase_q + PhaseW'(1) : phase_q;
  assign steps_nx = steps_q + StepW'(1);
  assign out_load = (state_q == StDone) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d   = state_q;
    g1_d      = g1_q;
    g2_d      = g2_q;
    value_d   = value_q;
    seed_d    = seed_q;
    lcg_d     = lcg_q;
    phase_d   = phase_q;
    steps_d   = steps_q;
    warm_d    = warm_q;
    seeding_d = seeding_q;
    emit_d    = emit_q;

    case (state_q)
      StIdle: begin
        if (accept) begin
          value_d   = '0;
          emit_d    = 1'b1;
          seeding_d = 1'b0;
          state_d   = StDone;
          case (in_i.opcode)
            OpDraw: begin
              state_d = StDrawA;
            end
            OpSeed: begin
              seed_d    = in_i.seed_value;
              lcg_d     = LcgAdd;
              phase_d   = '0;
              steps_d   = '0;
              g1_d      = '0;
              g2_d      = '0;
              seeding_d = 1'b1;
              state_d   = StLcg;
            end
            OpLoad: begin
              g1_d = {in_i.load_word0, in_i.load_word1};
              g2_d = {in_i.load_word2, in_i.load_word3};
            end
            default: begin
            end
          endcase
        end
      end
      StDrawA: begin
        g1_d    = mac_p;
        state_d = StDrawB;
      end
      StDrawB: begin
        g2_d = mac_p;
        if (!seeding_q) begin
          state_d = StSum;
        end else if (warm_q == WarmW'(WARMUP_DRAWS - 1)) begin
          state_d = StDone;
        end else begin
          warm_d  = warm_q + WarmW'(1);
          state_d = StDrawA;
        end
      end
      StSum: begin
        value_d = g1_q + {g2_q[WordW-1:0], g2_q[StateW-1:WordW]};
        state_d = StDone;
      end
      StLcg: begin
        lcg_d   = mac_p[WordW-1:0];
        steps_d = steps_nx;
        phase_d = phase_nx;
        if (z_keep) begin
          case (phase_q)
            PhaseW'(1): g2_d[WordW-1:0]      = z_word;
            PhaseW'(2): g1_d[WordW-1:0]      = z_word;
            PhaseW'(3): g2_d[StateW-1:WordW] = z_word;
            PhaseW'(4): g1_d[StateW-1:WordW] = z_word;
            default: begin
            end
          endcase
        end
        if (phase_nx == PhaseW'(SeedWords) || steps_nx == StepW'(SeedStepLimit)) begin
          lcg_d   = LcgAdd;
          phase_d = '0;
          steps_d = '0;
          warm_d  = '0;
          state_d = (WARMUP_DRAWS == 0) ? StDone : StDrawA;
        end
      end
      StDone: begin
        if (!emit_q || out_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load && emit_q) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLcg;
      g1_q        <= '0;
      g2_q        <= '0;
      value_q     <= '0;
      seed_q      <= '0;
      lcg_q       <= LcgAdd;
      phase_q     <= '0;
      steps_q     <= '0;
      warm_q      <= '0;
      seeding_q   <= 1'b1;
      emit_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      g1_q        <= g1_d;
      g2_q        <= g2_d;
      value_q     <= value_d;
      seed_q      <= seed_d;
      lcg_q       <= lcg_d;
      phase_q     <= phase_d;
      steps_q     <= steps_d;
      warm_q      <= warm_d;
      seeding_q   <= seeding_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && emit_q) begin
      out_value_q <= value_q;
      out_g1_q    <= g1_q;
      out_g2_q    <= g2_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.random_value = out_value_q;
  assign out_o.first_state  = out_g1_q;
  assign out_o.second_state = out_g2_q;

  a_draw_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.opcode == OpDraw) |=> (state_q == StDrawA))
    else $error("draw did not start the generator steps");

  a_load_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.opcode == OpLoad) |=>
      (g1_q == $past({in_i.load_word0, in_i.load_word1}) &&
       g2_q == $past({in_i.load_word2, in_i.load_word3})))
    else $error("load did not set both generator states");

  a_phase_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q <= PhaseW'(SeedWords) && steps_q <= StepW'(SeedStepLimit)))
    else $error("reseed counters out of range");

  a_seed_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && seeding_q) |-> (value_q == '0))
    else $error("reseed result carries a draw value");

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import dmrg_pkg::*;

  localparam int Warmup     = 13;
  localparam int RandomCmds = 1430;
  localparam int TailCmds   = 150;
  localparam int StuckLimit = 2000;
  localparam int DrainWait  = 100;

  localparam logic [1:0] OpUnused = 2'd3;

  typedef struct {
    logic [1:0]       op;
    logic [WordW-1:0] seed;
    logic [WordW-1:0] w0;
    logic [WordW-1:0] w1;
    logic [WordW-1:0] w2;
    logic [WordW-1:0] w3;
    bit               settle;
  } prng_cmd_t;

  typedef struct {
    logic [StateW-1:0] value;
    logic [StateW-1:0] first;
    logic [StateW-1:0] second;
  } prng_beat_t;

  logic clk_i;
  logic rst_ni;

  dmrg_in_if  in_bus ();
  dmrg_out_if out_bus ();

  dual_mwc_random_generator_unit #(
    .WARMUP_DRAWS(Warmup)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  logic [StateW-1:0] gen_a;
  logic [StateW-1:0] gen_b;

  prng_cmd_t  cmd_pending[$];
  prng_beat_t predicted_beats[$];
  prng_cmd_t  next_cmd;

  int   n_cmds       = 0;
  int   in_accepted  = 0;
  int   errors       = 0;
  int   stuck_cycles = 0;
  int   gap_left     = 0;
  int   stall_left   = 0;
  bit   holding      = 1'b0;
  logic in_fire      = 1'b0;
  logic tail_q       = 1'b0;

  function automatic logic [StateW-1:0] mwc_advance(logic [StateW-1:0] s,
                                                    logic [WordW-1:0] mul);
    logic [StateW-1:0] lo;
    logic [StateW-1:0] m;
    lo = {32'd0, s[31:0]};
    m  = {32'd0, mul};
    return lo * m + {32'd0, s[63:32]};
  endfunction

  function automatic logic [StateW-1:0] prng_draw();
    gen_a = mwc_advance(gen_a, MulOne);
    gen_b = mwc_advance(gen_b, MulTwo);
    return gen_a + {gen_b[31:0], gen_b[63:32]};
  endfunction

  function automatic void prng_reseed(logic [WordW-1:0] seed);
    logic [WordW-1:0] x;
    logic [WordW-1:0] z [SeedWords];
    int               n;
    int               k;
    for (k = 0; k < SeedWords; k++) z[k] = '0;
    x = LcgAdd;
    n = 0;
    for (k = 0; k < SeedStepLimit && n < SeedWords; k++) begin
      x = (x + seed) * LcgMul + LcgAdd;
      if (x[30:0] != 31'd0) begin
        z[n] = {1'b0, x[30:0]};
        n++;
      end
    end
    gen_a = {z[4], z[2]};
    gen_b = {z[3], z[1]};
    for (k = 0; k < Warmup; k++) void'(prng_draw());
  endfunction

  function automatic prng_beat_t prng_predict(logic [1:0] op, logic [WordW-1:0] seed,
                                              logic [WordW-1:0] w0, logic [WordW-1:0] w1,
                                              logic [WordW-1:0] w2, logic [WordW-1:0] w3);
    prng_beat_t b;
    b.value = '0;
    case (op)
      OpDraw: b.value = prng_draw();
      OpSeed: prng_reseed(seed);
      OpLoad: begin
        gen_a = {w0, w1};
        gen_b = {w2, w3};
      end
      default: ;
    endcase
    b.first  = gen_a;
    b.second = gen_b;
    return b;
  endfunction

  // seed whose first LCG step lands on target, so a word is thrown away
  function automatic logic [WordW-1:0] reject_seed(logic [WordW-1:0] target);
    logic [WordW-1:0] inv;
    int               k;
    inv = LcgMul;
    for (k = 0; k < 5; k++) inv = inv * (32'd2 - LcgMul * inv);
    return (target - LcgAdd) * inv - LcgAdd;
  endfunction

  function automatic logic [WordW-1:0] random_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_cmd(logic [1:0] op, logic [WordW-1:0] seed,
                                  logic [WordW-1:0] w0, logic [WordW-1:0] w1,
                                  logic [WordW-1:0] w2, logic [WordW-1:0] w3,
                                  bit settle = 1'b0);
    prng_cmd_t c;
    c.op     = op;
    c.seed   = seed;
    c.w0     = w0;
    c.w1     = w1;
    c.w2     = w2;
    c.w3     = w3;
    c.settle = settle;
    cmd_pending.push_back(c);
  endfunction

  function automatic void add_random_cmd(bit settle);
    int               r;
    logic [1:0]       op;
    logic [WordW-1:0] seed;
    r    = $urandom_range(0, 99);
    seed = $urandom;
    if (r < 68) begin
      op = OpDraw;
    end else if (r < 80) begin
      op = OpSeed;
      case ($urandom_range(0, 7))
        0, 1:    seed = reject_seed({$urandom_range(0, 1) == 1, 31'd0});
        2:       seed = '0;
        3:       seed = '1;
        default: ;
      endcase
    end else if (r < 94) begin
      op = OpLoad;
    end else begin
      op = OpUnused;
    end
    add_cmd(op, seed, random_word(), random_word(), random_word(), random_word(), settle);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni             = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.opcode      = '0;
    in_bus.seed_value  = '0;
    in_bus.load_word0  = '0;
    in_bus.load_word1  = '0;
    in_bus.load_word2  = '0;
    in_bus.load_word3  = '0;
    out_bus.ready      = 1'b0;

    prng_reseed('0);

    add_cmd(OpDraw, '0, '0, '0, '0, '0);
    add_cmd(OpDraw, '1, '1, '1, '1, '1);
    add_cmd(OpUnused, '1, '1, '1, '1, '1);
    add_cmd(OpSeed, '0, '0, '0, '0, '0);
    add_cmd(OpDraw, '0, '0, '0, '0, '0);
    add_cmd(OpSeed, '1, '0, '0, '0, '0);
    add_cmd(OpDraw, '0, '0, '0, '0, '0);
    add_cmd(OpSeed, 32'h0000_0001, '0, '0, '0, '0);
    add_cmd(OpSeed, 32'h8000_0000, '0, '0, '0, '0);
    add_cmd(OpSeed, reject_seed(32'h0000_0000), '0, '0, '0, '0);
    add_cmd(OpDraw, '0, '0, '0, '0, '0);
    add_cmd(OpSeed, reject_seed(32'h8000_0000), '0, '0, '0, '0);
    add_cmd(OpDraw, '0, '0, '0, '0, '0);
    add_cmd(OpLoad, '0, '0, '0, '0, '0);
    add_cmd(OpDraw, '0, '0, '0, '0, '0);
    add_cmd(OpDraw, '0, '0, '0, '0, '0);
    add_cmd(OpLoad, '0, '1, '1, '1, '1);
    add_cmd(OpDraw, '0, '0, '0, '0, '0, 1'b1);
    add_cmd(OpDraw, '0, '0, '0, '0, '0);
    add_cmd(OpLoad, '0, '1, '0, '1, '0);
    add_cmd(OpDraw, '0, '0, '0, '0, '0);
    add_cmd(OpLoad, '1, $urandom, $urandom, $urandom, $urandom);
    add_cmd(OpDraw, '0, '0, '0, '0, '0);
    add_cmd(OpUnused, '0, '0, '0, '0, '0);
    add_cmd(OpDraw, '0, '0, '0, '0, '0);

    for (int i = 0; i < RandomCmds; i++) add_random_cmd(i % 350 == 349);
    n_cmds = cmd_pending.size();

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (!(in_accepted == n_cmds && predicted_beats.size() == 0));
    repeat (DrainWait) @(negedge clk_i);

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    while (stuck_cycles < StuckLimit) @(negedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_fire) holding = 1'b0;
      if (!holding) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (cmd_pending.size() != 0 &&
                     !(cmd_pending[0].settle && predicted_beats.size() != 0)) begin
          if (!tail_q && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(0, 8);
          end else begin
            next_cmd = cmd_pending.pop_front();
            in_bus.opcode     <= next_cmd.op;
            in_bus.seed_value <= next_cmd.seed;
            in_bus.load_word0 <= next_cmd.w0;
            in_bus.load_word1 <= next_cmd.w1;
            in_bus.load_word2 <= next_cmd.w2;
            in_bus.load_word3 <= next_cmd.w3;
            holding = 1'b1;
          end
        end
      end
      in_bus.valid <= holding;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else if (tail_q) begin
      out_bus.ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_bus.ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    logic       in_beat;
    logic       out_beat;
    prng_beat_t exp_beat;
    in_beat  = rst_ni && (in_bus.valid === 1'b1) && (in_bus.ready === 1'b1);
    out_beat = rst_ni && (out_bus.valid === 1'b1) && (out_bus.ready === 1'b1);

    if (out_beat) begin
      if (predicted_beats.size() == 0) begin
        $display("%0t: unexpected beat value %h first %h second %h", $time,
                 out_bus.random_value, out_bus.first_state, out_bus.second_state);
        errors++;
      end else begin
        exp_beat = predicted_beats.pop_front();
        if (out_bus.random_value !== exp_beat.value) begin
          $display("%0t: random_value expected %h actual %h", $time,
                   exp_beat.value, out_bus.random_value);
          errors++;
        end
        if (out_bus.first_state !== exp_beat.first) begin
          $display("%0t: first_state expected %h actual %h", $time,
                   exp_beat.first, out_bus.first_state);
          errors++;
        end
        if (out_bus.second_state !== exp_beat.second) begin
          $display("%0t: second_state expected %h actual %h", $time,
                   exp_beat.second, out_bus.second_state);
          errors++;
        end
      end
    end

    if (in_beat) begin
      predicted_beats.push_back(prng_predict(in_bus.opcode, in_bus.seed_value,
                                             in_bus.load_word0, in_bus.load_word1,
                                             in_bus.load_word2, in_bus.load_word3));
      in_accepted++;
    end

    in_fire      <= in_beat;
    tail_q       <= cmd_pending.size() < TailCmds;
    stuck_cycles <= (in_beat || out_beat) ? 0 : stuck_cycles + 1;
  end

endmodule

// ----- sim.f -----
src/dmrg_pkg.sv
src/dmrg_if.sv
src/dmrg_mac.sv
src/dual_mwc_random_generator_unit.sv
tb/sv/tb.sv
